// ===== rtl/cdma_pkg.sv =====
// ----------------------------------------------------------------------------
// cdma_pkg
// Shared types, constants and helpers for the complex binary64 multiply-
// accumulate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cdma_pkg;

    localparam int FMA_LAT = 10;
    localparam int EW      = 14;

    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [62:0] EXP_INF     = 63'h7FF0_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

    typedef logic signed [EW-1:0] t_exp;

    // front end to rounder
    typedef struct packed {
        logic         spec;
        logic [63:0]  sval;
        logic         sign;
        logic [127:0] mag;
        t_exp         e;
    } t_sum;

    typedef struct packed {
        logic [63:0] a_re;
        logic [63:0] b_re;
        logic [63:0] b_im;
        logic        last;
    } t_side;

    function automatic logic is_nan(input logic [63:0] x);
        return x[62:0] > EXP_INF;
    endfunction

    function automatic logic is_inf(input logic [63:0] x);
        return x[62:0] == EXP_INF;
    endfunction

    function automatic logic is_zero(input logic [63:0] x);
        return x[62:0] == 63'd0;
    endfunction

    function automatic logic [63:0] negate(input logic [63:0] x);
        return is_nan(x) ? x : {~x[63], x[62:0]};
    endfunction

    function automatic logic [6:0] msb_pos(input logic [127:0] x);
        logic [6:0] p;
        p = '0;
        for (int i = 0; i < 128; i++) begin
            if (x[i]) p = 7'(i);
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cdma_if.sv =====
// ----------------------------------------------------------------------------
// cdma_if
// Valid/ready channels for operand and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdma_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] a_re;
    logic [63:0] a_im;
    logic [63:0] b_re;
    logic [63:0] b_im;
    logic [63:0] acc_re;
    logic [63:0] acc_im;
    logic        last_in;

    modport source (output valid, a_re, a_im, b_re, b_im, acc_re, acc_im, last_in,
                    input ready);
    modport sink   (input valid, a_re, a_im, b_re, b_im, acc_re, acc_im, last_in,
                    output ready);
endinterface

interface cdma_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] sum_re;
    logic [63:0] sum_im;
    logic        last_out;

    modport source (output valid, sum_re, sum_im, last_out, input ready);
    modport sink   (input valid, sum_re, sum_im, last_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/cdma_fma_front.sv =====
// ----------------------------------------------------------------------------
// cdma_fma_front
// FMA front end: special cases, 53x53 product from four partial products,
// normalization, alignment with sticky and the wide add. Seven stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cdma_fma_front (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    input  wire logic [63:0]  i_c,
    output cdma_pkg::t_sum    o_sum
);

    function automatic logic [52:0] unp_m(input logic [63:0] x);
        return (x[62:52] == 11'd0) ? {1'b0, x[51:0]} : {1'b1, x[51:0]};
    endfunction

    function automatic cdma_pkg::t_exp unp_e(input logic [63:0] x);
        return (x[62:52] == 11'd0) ? -14'sd1074 : ($signed({3'b000, x[62:52]}) - 14'sd1075);
    endfunction

    // stage 1
    logic                 n_spec;
    logic [63:0]          n_sval;
    logic [52:0]          n_ma, n_mb;
    logic                 ps;
    logic [53:0]          r1_pll;
    logic [52:0]          r1_plh, r1_phl;
    logic [51:0]          r1_phh;
    cdma_pkg::t_exp       r1_ep, r1_ec;
    logic [52:0]          r1_mc;
    logic                 r1_cz, r1_ps, r1_sc, r1_spec;
    logic [63:0]          r1_sval;

    assign ps   = i_a[63] ^ i_b[63];
    assign n_ma = unp_m(i_a);
    assign n_mb = unp_m(i_b);

    always_comb begin
        n_spec = 1'b1;
        n_sval = '0;
        if (cdma_pkg::is_nan(i_a)) begin
            n_sval = i_a | cdma_pkg::QUIET_BIT;
        end else if (cdma_pkg::is_nan(i_b)) begin
            n_sval = i_b | cdma_pkg::QUIET_BIT;
        end else if (cdma_pkg::is_nan(i_c)) begin
            n_sval = i_c | cdma_pkg::QUIET_BIT;
        end else if (cdma_pkg::is_inf(i_a) || cdma_pkg::is_inf(i_b)) begin
            if (cdma_pkg::is_zero(i_a) || cdma_pkg::is_zero(i_b)) begin
                n_sval = cdma_pkg::DEFAULT_NAN;
            end else if (cdma_pkg::is_inf(i_c) && (i_c[63] != ps)) begin
                n_sval = cdma_pkg::DEFAULT_NAN;
            end else begin
                n_sval = {ps, cdma_pkg::EXP_INF};
            end
        end else if (cdma_pkg::is_inf(i_c)) begin
            n_sval = i_c;
        end else if (cdma_pkg::is_zero(i_a) || cdma_pkg::is_zero(i_b)) begin
            if (cdma_pkg::is_zero(i_c)) n_sval = {ps & i_c[63], 63'd0};
            else n_sval = i_c;
        end else begin
            n_spec = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pll  <= 54'(n_ma[26:0]) * 54'(n_mb[26:0]);
            r1_plh  <= 53'(n_ma[26:0]) * 53'(n_mb[52:27]);
            r1_phl  <= 53'(n_ma[52:27]) * 53'(n_mb[26:0]);
            r1_phh  <= 52'(n_ma[52:27]) * 52'(n_mb[52:27]);
            r1_ep   <= unp_e(i_a) + unp_e(i_b);
            r1_ec   <= unp_e(i_c);
            r1_mc   <= unp_m(i_c);
            r1_cz   <= cdma_pkg::is_zero(i_c);
            r1_ps   <= ps;
            r1_sc   <= i_c[63];
            r1_spec <= n_spec;
            r1_sval <= n_sval;
        end
    end

    // stage 2: product sum, addend msb
    logic [105:0]   r2_p;
    logic [6:0]     r2_cpos;
    cdma_pkg::t_exp r2_ep, r2_ec;
    logic [52:0]    r2_mc;
    logic           r2_cz, r2_ps, r2_sc, r2_spec;
    logic [63:0]    r2_sval;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p    <= 106'(r1_pll) + (106'(r1_plh) << 27) + (106'(r1_phl) << 27)
                       + (106'(r1_phh) << 54);
            r2_cpos <= cdma_pkg::msb_pos({75'd0, r1_mc});
            r2_ep   <= r1_ep;
            r2_ec   <= r1_ec;
            r2_mc   <= r1_mc;
            r2_cz   <= r1_cz;
            r2_ps   <= r1_ps;
            r2_sc   <= r1_sc;
            r2_spec <= r1_spec;
            r2_sval <= r1_sval;
        end
    end

    // stage 3: product msb
    logic [105:0]   r3_p;
    logic [6:0]     r3_ppos, r3_cpos;
    cdma_pkg::t_exp r3_ep, r3_ec;
    logic [52:0]    r3_mc;
    logic           r3_cz, r3_ps, r3_sc, r3_spec;
    logic [63:0]    r3_sval;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_p    <= r2_p;
            r3_ppos <= cdma_pkg::msb_pos({22'd0, r2_p});
            r3_cpos <= r2_cpos;
            r3_ep   <= r2_ep;
            r3_ec   <= r2_ec;
            r3_mc   <= r2_mc;
            r3_cz   <= r2_cz;
            r3_ps   <= r2_ps;
            r3_sc   <= r2_sc;
            r3_spec <= r2_spec;
            r3_sval <= r2_sval;
        end
    end

    // stage 4: normalize both to bit 125
    logic [6:0]     sp, sc4;
    logic [127:0]   r4_pn, r4_cn;
    cdma_pkg::t_exp r4_ep, r4_ec;
    logic           r4_cz, r4_ps, r4_sc, r4_spec;
    logic [63:0]    r4_sval;

    assign sp  = 7'd125 - r3_ppos;
    assign sc4 = 7'd125 - r3_cpos;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_pn   <= {22'd0, r3_p} << sp;
            r4_cn   <= {75'd0, r3_mc} << sc4;
            r4_ep   <= r3_ep - $signed({7'd0, sp});
            r4_ec   <= r3_ec - $signed({7'd0, sc4});
            r4_cz   <= r3_cz;
            r4_ps   <= r3_ps;
            r4_sc   <= r3_sc;
            r4_spec <= r3_spec;
            r4_sval <= r3_sval;
        end
    end

    // stage 5: order operands
    logic           pbig;
    cdma_pkg::t_exp d5;
    logic [127:0]   r5_x, r5_y;
    logic           r5_sx, r5_sy, r5_spec;
    logic [6:0]     r5_amt;
    cdma_pkg::t_exp r5_e;
    logic [63:0]    r5_sval;

    assign pbig = r4_cz || (r4_ep > r4_ec) || ((r4_ep == r4_ec) && (r4_pn >= r4_cn));
    assign d5   = pbig ? (r4_ep - r4_ec) : (r4_ec - r4_ep);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_x    <= pbig ? r4_pn : r4_cn;
            r5_y    <= pbig ? (r4_cz ? 128'd0 : r4_cn) : r4_pn;
            r5_sx   <= pbig ? r4_ps : r4_sc;
            r5_sy   <= pbig ? (r4_cz ? r4_ps : r4_sc) : r4_ps;
            r5_amt  <= (d5 > 14'sd127) ? 7'd127 : d5[6:0];
            r5_e    <= pbig ? r4_ep : r4_ec;
            r5_spec <= r4_spec;
            r5_sval <= r4_sval;
        end
    end

    // stage 6: align with sticky
    logic [127:0]   mask6, yj;
    logic [127:0]   r6_x, r6_y;
    logic           r6_sub, r6_sx, r6_spec;
    cdma_pkg::t_exp r6_e;
    logic [63:0]    r6_sval;

    assign mask6 = ~({128{1'b1}} << r5_amt);
    assign yj    = (r5_y >> r5_amt) | {127'd0, |(r5_y & mask6)};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_x    <= r5_x;
            r6_y    <= yj;
            r6_sub  <= r5_sx != r5_sy;
            r6_sx   <= r5_sx;
            r6_e    <= r5_e;
            r6_spec <= r5_spec;
            r6_sval <= r5_sval;
        end
    end

    // stage 7: add
    cdma_pkg::t_sum r7_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_sum.mag  <= r6_sub ? (r6_x - r6_y) : (r6_x + r6_y);
            r7_sum.sign <= r6_sx;
            r7_sum.e    <= r6_e;
            r7_sum.spec <= r6_spec;
            r7_sum.sval <= r6_sval;
        end
    end

    assign o_sum = r7_sum;

endmodule

`default_nettype wire

// ===== rtl/cdma_round.sv =====
// ----------------------------------------------------------------------------
// cdma_round
// Rounds sign * mag * 2^e to binary64, nearest-even, with gradual underflow.
// Three stages: msb search, shift with guard/sticky, increment and pack.
// ----------------------------------------------------------------------------
`default_nettype none

module cdma_round (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  cdma_pkg::t_sum     i_sum,
    output logic [63:0]        o_res
);

    // stage 1
    cdma_pkg::t_sum r1_sum;
    logic [6:0]     r1_pos;
    logic           r1_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sum  <= i_sum;
            r1_pos  <= cdma_pkg::msb_pos(i_sum.mag);
            r1_zero <= i_sum.mag == 128'd0;
        end
    end

    // stage 2
    cdma_pkg::t_exp sha, shb, sh, nsh;
    logic [6:0]     s1;
    logic [127:0]   q;
    logic [53:0]    n_mant;
    logic           n_rnd, n_st;
    logic [53:0]    r2_mant;
    logic           r2_rnd, r2_st, r2_sign, r2_zero, r2_spec;
    cdma_pkg::t_exp r2_el;
    logic [63:0]    r2_sval;

    assign sha = $signed({7'd0, r1_pos}) - 14'sd52;
    assign shb = -14'sd1074 - r1_sum.e;
    assign sh  = (shb > sha) ? shb : sha;
    assign nsh = -sh;
    assign s1  = sh[6:0] - 7'd1;
    assign q   = r1_sum.mag >> s1;

    always_comb begin
        n_mant = '0;
        n_rnd  = 1'b0;
        n_st   = 1'b0;
        if (sh <= 14'sd0) begin
            n_mant = 54'(r1_sum.mag[52:0]) << nsh[5:0];
        end else if (sh <= 14'sd127) begin
            n_mant = q[54:1];
            n_rnd  = q[0];
            n_st   = |(r1_sum.mag & ~({128{1'b1}} << s1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mant <= n_mant;
            r2_rnd  <= n_rnd;
            r2_st   <= n_st;
            r2_el   <= r1_sum.e + sh;
            r2_sign <= r1_sum.sign;
            r2_zero <= r1_zero;
            r2_spec <= r1_sum.spec;
            r2_sval <= r1_sum.sval;
        end
    end

    // stage 3
    logic [53:0]    m2, m3;
    cdma_pkg::t_exp el3, biased;
    logic [63:0]    n_res;
    logic [63:0]    r3_res;

    assign m2     = r2_mant + 54'(r2_rnd && (r2_st || r2_mant[0]));
    assign m3     = m2[53] ? (m2 >> 1) : m2;
    assign el3    = m2[53] ? (r2_el + 14'sd1) : r2_el;
    assign biased = el3 + 14'sd1075;

    always_comb begin
        if (r2_spec) begin
            n_res = r2_sval;
        end else if (r2_zero) begin
            n_res = '0;
        end else if (!m3[52]) begin
            n_res = {r2_sign, 11'd0, m3[51:0]};
        end else if (biased >= 14'sd2047) begin
            n_res = {r2_sign, cdma_pkg::EXP_INF};
        end else begin
            n_res = {r2_sign, biased[10:0], m3[51:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_res <= n_res;
        end
    end

    assign o_res = r3_res;

endmodule

`default_nettype wire

// ===== rtl/cdma_fma.sv =====
// ----------------------------------------------------------------------------
// cdma_fma
// Pipelined binary64 fused multiply-add a*b + c, one rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module cdma_fma (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    input  wire logic [63:0]  i_c,
    output logic [63:0]       o_res
);

    cdma_pkg::t_sum sum;

    cdma_fma_front u_front (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_a),
        .i_b   (i_b),
        .i_c   (i_c),
        .o_sum (sum)
    );

    cdma_round u_round (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_sum (sum),
        .o_res (o_res)
    );

endmodule

`default_nettype wire

// ===== rtl/complex_double_multiply_accumulate.sv =====
// Datapath: two chained 10-stage FMAs from input beat to result beat.
// Throughput: one beat per cycle; the whole pipeline holds while a result is
// stalled at the output register.
// Reset: synchronous, active low; clears all valid bits, data registers keep.
// ----------------------------------------------------------------------------
// complex_double_multiply_accumulate
// r + a*b on complex binary64 operands: t and u FMAs in parallel, then the
// final real and imaginary FMAs.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_double_multiply_accumulate (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cdma_in_if.sink    i_in,
    cdma_out_if.source o_out
);

    localparam int LAT = cdma_pkg::FMA_LAT;

    logic                  en;
    logic [2*LAT-1:0]      r_vld;
    cdma_pkg::t_side       r_side [LAT];
    logic [LAT-1:0]        r_last;
    logic [63:0]           t_res, u_res, re_res, im_res;

    assign en         = !r_vld[2*LAT-1] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[2*LAT-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= '{a_re: i_in.a_re, b_re: i_in.b_re, b_im: i_in.b_im,
                           last: i_in.last_in};
            for (int k = 1; k < LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_last <= {r_last[LAT-2:0], r_side[LAT-1].last};
        end
    end

    cdma_fma u_fma_t (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (i_in.a_im),
        .i_b   (i_in.b_im),
        .i_c   (cdma_pkg::negate(i_in.acc_re)),
        .o_res (t_res)
    );

    cdma_fma u_fma_u (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (i_in.a_im),
        .i_b   (i_in.b_re),
        .i_c   (i_in.acc_im),
        .o_res (u_res)
    );

    cdma_fma u_fma_re (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_side[LAT-1].a_re),
        .i_b   (r_side[LAT-1].b_re),
        .i_c   (cdma_pkg::negate(t_res)),
        .o_res (re_res)
    );

    cdma_fma u_fma_im (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_side[LAT-1].a_re),
        .i_b   (r_side[LAT-1].b_im),
        .i_c   (u_res),
        .o_res (im_res)
    );

    assign o_out.valid    = r_vld[2*LAT-1];
    assign o_out.sum_re   = re_res;
    assign o_out.sum_im   = im_res;
    assign o_out.last_out = r_last[LAT-1];

endmodule

`default_nettype wire

// ===== rtl/cdma_chk.sv =====
// ----------------------------------------------------------------------------
// cdma_chk
// Port-level checks for the complex multiply-accumulate, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module cdma_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] i_sum_re,
    input wire logic [63:0] i_sum_im
);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sum_re)
        && $stable(i_sum_im))
        else $error("result beat changed under stall");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |-> i_in_ready)
        else $error("input blocked while output drains");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result beat right after reset");

endmodule

bind complex_double_multiply_accumulate cdma_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_sum_re    (o_out.sum_re),
    .i_sum_im    (o_out.sum_im)
);

`default_nettype wire

// ===== verif/complex_double_multiply_accumulate_checker.sv =====
// ----------------------------------------------------------------------------
// complex_double_multiply_accumulate_checker
// Watches the operand and result channels, computes r + a*b by four rounded
// integer-arithmetic FMAs for every accepted operand beat and compares each
// result beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module complex_double_multiply_accumulate_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cdma_in_if.sink   i_in,
    cdma_out_if.sink  i_out,
    output int        o_errors,
    output int        o_pending,
    output int        o_results
);

    localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;
    localparam logic [63:0] FRAC_MSK  = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] HIDDEN    = 64'h0010_0000_0000_0000;
    localparam logic [63:0] INF_PAT   = 64'h7FF0_0000_0000_0000;

    typedef struct {
        logic [63:0] re;
        logic [63:0] im;
        logic        last;
    } t_cplx_sum;

    t_cplx_sum sums_due[$];

    function automatic logic nan_p(input logic [63:0] x);
        return x[62:0] > INF_PAT[62:0];
    endfunction

    function automatic logic inf_p(input logic [63:0] x);
        return x[62:0] == INF_PAT[62:0];
    endfunction

    function automatic logic zero_p(input logic [63:0] x);
        return x[62:0] == 63'd0;
    endfunction

    function automatic int top_bit(input logic [127:0] x);
        int p;
        p = -1;
        for (int i = 0; i < 128; i++) if (x[i]) p = i;
        return p;
    endfunction

    function automatic logic [63:0] flip(input logic [63:0] x);
        return nan_p(x) ? x : (x ^ SIGN_MASK);
    endfunction

    function automatic logic [63:0] pack_round(input logic s, input logic [127:0] r,
                                               input int e);
        int sh, el, biased;
        logic [127:0] q;
        logic [63:0] mant;
        logic rnd, sticky;
        sh = top_bit(r) - 52;
        if (-1074 - e > sh) sh = -1074 - e;
        if (sh <= 0) begin
            mant = r[63:0] << (-sh);
            el = e + sh;
        end else begin
            q = r >> (sh - 1);
            rnd = q[0];
            sticky = (q << (sh - 1)) != r;
            mant = 64'(q >> 1);
            el = e + sh;
            if (rnd && (sticky || mant[0])) mant++;
            if (mant[53]) begin
                mant = mant >> 1;
                el++;
            end
        end
        if (mant >= HIDDEN) begin
            biased = el + 1075;
            if (biased >= 2047) return {s, INF_PAT[62:0]};
            return {s, 11'(biased), mant[51:0]};
        end
        return {s, mant[62:0]};
    endfunction

    function automatic void split(input logic [63:0] x, output logic [127:0] m,
                                  output int e);
        if (x[62:52] == 11'd0) begin
            m = {64'd0, x & FRAC_MSK};
            e = -1074;
        end else begin
            m = {64'd0, (x & FRAC_MSK) | HIDDEN};
            e = int'(x[62:52]) - 1075;
        end
    endfunction

    function automatic logic [63:0] fused_mul_add(input logic [63:0] a, b, c);
        logic ps, sx, sy;
        logic [127:0] ma, mb, mc, p, x, y, r, t;
        int ea, eb, ec, ep, dx, d;
        ps = a[63] ^ b[63];
        if (nan_p(a)) return a | cdma_pkg::QUIET_BIT;
        if (nan_p(b)) return b | cdma_pkg::QUIET_BIT;
        if (nan_p(c)) return c | cdma_pkg::QUIET_BIT;
        if (inf_p(a) || inf_p(b)) begin
            if (zero_p(a) || zero_p(b)) return cdma_pkg::DEFAULT_NAN;
            if (inf_p(c) && c[63] != ps) return cdma_pkg::DEFAULT_NAN;
            return {ps, INF_PAT[62:0]};
        end
        if (inf_p(c)) return c;
        if (zero_p(a) || zero_p(b)) begin
            if (zero_p(c)) return (ps && c[63]) ? SIGN_MASK : 64'd0;
            return c;
        end
        split(a, ma, ea);
        split(b, mb, eb);
        p = ma * mb;
        ep = ea + eb;
        if (zero_p(c)) return pack_round(ps, p, ep);
        split(c, mc, ec);
        dx = 125 - top_bit(p);
        p = p << dx;
        ep -= dx;
        dx = 125 - top_bit(mc);
        mc = mc << dx;
        ec -= dx;
        if (ep > ec || (ep == ec && p >= mc)) begin
            x = p; sx = ps; t = mc; sy = c[63]; d = ep - ec; dx = ep;
        end else begin
            x = mc; sx = c[63]; t = p; sy = ps; d = ec - ep; dx = ec;
        end
        y = (d >= 128) ? 128'd0 : (t >> d);
        if (((d >= 128) ? 128'd0 : (y << d)) != t) y[0] = 1'b1;
        r = (sx == sy) ? x + y : x - y;
        if (r == 128'd0) return 64'd0;
        return pack_round(sx, r, dx);
    endfunction

    task automatic report(input string what, input logic [63:0] got, want);
        $display("mismatch %s: got %h want %h", what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
    end

    assign o_pending = sums_due.size();

    always @(posedge i_clk) begin
        t_cplx_sum s, w;
        logic [63:0] t, u;
        if (i_rst_n && i_in.valid && i_in.ready) begin
            t = fused_mul_add(i_in.a_im, i_in.b_im, flip(i_in.acc_re));
            u = fused_mul_add(i_in.a_im, i_in.b_re, i_in.acc_im);
            s.re = fused_mul_add(i_in.a_re, i_in.b_re, flip(t));
            s.im = fused_mul_add(i_in.a_re, i_in.b_im, u);
            s.last = i_in.last_in;
            sums_due.push_back(s);
        end
        if (i_rst_n && i_out.valid && i_out.ready) begin
            o_results++;
            if (sums_due.size() == 0) begin
                report("unexpected beat", i_out.sum_re, i_out.sum_im);
            end else begin
                w = sums_due.pop_front();
                if (i_out.sum_re !== w.re) report("sum_re", i_out.sum_re, w.re);
                if (i_out.sum_im !== w.im) report("sum_im", i_out.sum_im, w.im);
                if (i_out.last_out !== w.last)
                    report("last_out", 64'(i_out.last_out), 64'(w.last));
            end
        end
    end
endmodule

`default_nettype wire

// ===== verif/complex_double_multiply_accumulate_test.sv =====
// ----------------------------------------------------------------------------
// complex_double_multiply_accumulate_test
// Drives directed special-value beats and random complex MAC beats with
// random source gaps and sink stalls; the checker does the comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module complex_double_multiply_accumulate_test;
    localparam int N_RANDOM  = 1330;
    localparam int MAX_CYCLE = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending, results, cycles = 0;
    int   out_wait = 0;

    cdma_in_if  op_ch();
    cdma_out_if res_ch();

    complex_double_multiply_accumulate DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(op_ch.sink), .o_out(res_ch.source)
    );

    complex_double_multiply_accumulate_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(op_ch.sink), .i_out(res_ch.sink),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0: v = {v[63], 63'd0};
            1: v = {v[63], 11'h7FF, 52'd0};
            2: v = {v[63], 11'h7FF, v[51:0] | 52'd1};
            3: v = {v[63], 11'd0, v[51:0]};
            4: v = {v[63], 11'h7FE, v[51:0]};
            5: v = {v[63], 11'(1023 + $urandom_range(0, 8) - 4), v[51:0]};
            6: v = {v[63], 11'(1023 + $urandom_range(0, 80) - 40), v[51:0]};
            7: v = {v[63], 11'($urandom_range(1, 60)), v[51:0]};
            default: v = {v[63], 11'($urandom_range(900, 1150)), v[51:0]};
        endcase
        return v;
    endfunction

    task automatic send(input logic [63:0] ar, ai, br, bi, cr, ci, input logic lst);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            op_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        op_ch.valid <= 1'b1;
        op_ch.a_re <= ar; op_ch.a_im <= ai; op_ch.b_re <= br; op_ch.b_im <= bi;
        op_ch.acc_re <= cr; op_ch.acc_im <= ci; op_ch.last_in <= lst;
        do @(posedge i_clk); while (!op_ch.ready);
        @(negedge i_clk);
    endtask

    // sink stall drawn per result beat
    always @(posedge i_clk) begin
        if (res_ch.valid && res_ch.ready)
            out_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    end

    always @(negedge i_clk) begin
        if (out_wait > 0) begin
            res_ch.ready <= 1'b0;
            out_wait--;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    initial begin
        logic [63:0] one, ninf, pinf, snan, sub, big, nz;
        one = 64'h3FF0_0000_0000_0000; pinf = 64'h7FF0_0000_0000_0000;
        ninf = 64'hFFF0_0000_0000_0000; snan = 64'h7FF0_0000_0000_0001;
        sub = 64'h0000_0000_0000_0001; big = 64'h7FEF_FFFF_FFFF_FFFF;
        nz = 64'h8000_0000_0000_0000;
        op_ch.valid = 1'b0; op_ch.a_re = '0; op_ch.a_im = '0; op_ch.b_re = '0;
        op_ch.b_im = '0; op_ch.acc_re = '0; op_ch.acc_im = '0; op_ch.last_in = 1'b0;
        res_ch.ready = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        send(one, one, one, one, one, one, 1'b0);
        send('0, '0, '0, '0, '0, '0, 1'b1);
        send(nz, nz, nz, nz, nz, nz, 1'b0);
        send(nz, one, '0, one, nz, nz, 1'b1);
        send(pinf, '0, one, one, one, one, 1'b0);
        send(one, pinf, one, one, pinf, ninf, 1'b0);
        send(one, one, pinf, pinf, ninf, pinf, 1'b1);
        send(snan, one, one, one, one, one, 1'b0);
        send(one, one, one, one, 64'hFFF4_0000_0000_0123, snan, 1'b0);
        send(big, big, big, big, big, big, 1'b1);
        send(big, nz | big, big, big, '0, '0, 1'b0);
        send(sub, sub, sub, sub, sub, sub, 1'b0);
        send(64'h3CB0_0000_0000_0000, sub, 64'h0010_0000_0000_0000, one, sub, nz, 1'b1);
        send(one, one, one, one, 64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000,
             1'b0);
        send(64'h3FF0_0000_0000_0001, 64'h3FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0001,
             64'h3FEF_FFFF_FFFF_FFFF, one, nz | one, 1'b1);
        send('1, '1, '1, '1, '1, '1, 1'b1);
        send(pinf, one, '0, one, one, one, 1'b0);
        send(nz | 64'h7FF8_0000_0000_0005, snan, one, one, one, one, 1'b1);
        for (int n = 0; n < N_RANDOM; n++)
            send(pick_value(), pick_value(), pick_value(), pick_value(),
                 pick_value(), pick_value(), 1'($urandom));
        op_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (60) @(negedge i_clk);
        $display("sent %0d directed and random complex MAC beats, %0d results checked",
                 N_RANDOM + 18, results);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
rtl/cdma_pkg.sv
rtl/cdma_if.sv
rtl/cdma_fma_front.sv
rtl/cdma_round.sv
rtl/cdma_fma.sv
rtl/complex_double_multiply_accumulate.sv
rtl/cdma_chk.sv
verif/complex_double_multiply_accumulate_checker.sv
verif/complex_double_multiply_accumulate_test.sv
